>>> hdl/tilt_gait_stim_trigger_assert.svh
// Assertion macros for the tilt gait stimulation trigger checker.
// Needs nothing else; included by the checker file only.
`ifndef TILT_GAIT_STIM_TRIGGER_ASSERT_SVH
`define TILT_GAIT_STIM_TRIGGER_ASSERT_SVH

// Property checked on every rising edge, suspended while reset is held
`define TGST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define TGST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/tgst_pkg.sv
// Shared types, constants and the arctangent table for the tilt gait trigger.
// Used by the channel interfaces, the top level and the checker.
package tgst_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int ATAN_ENTRIES        = 24;
  localparam int ATAN_IDX_W          = 5;
  localparam int ATAN_W              = 22;

  // CORDIC datapath: 16-bit inputs scaled by 2^16, gain growth fits in 36 bits
  localparam int DATA_W = 36;
  localparam int ANG_W  = 25;
  localparam int MUL_W  = 17;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic               AXIS_SELECT_RST   = 1'b0;
  localparam logic signed [15:0] TROUGH_LIMIT_RST  = -16'sd384;
  localparam logic signed [15:0] ARM_LIMIT_RST     = -16'sd6400;
  localparam logic        [15:0] RELEASE_RISE_RST  = 16'd15360;
  localparam logic        [15:0] TIMEOUT_TICKS_RST = 16'd750;

  typedef enum logic [2:0] {
    REG_AXIS_SELECT   = 3'd0,
    REG_TROUGH_LIMIT  = 3'd1,
    REG_ARM_LIMIT     = 3'd2,
    REG_RELEASE_RISE  = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_PASS2,
    ST_ROUND,
    ST_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_RISE    = 2'd1,
    CAUSE_TIMEOUT = 2'd2
  } stop_cause_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/tgst_if.sv
// Request channels of the tilt gait trigger: accelerometer/tick in, result out.
// Depends on tgst_pkg.
interface tgst_sample_if;
  import tgst_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, op, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, op, accel_x, accel_y, accel_z, output ready);
endinterface

interface tgst_result_if;
  import tgst_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] tilt_angle;
  logic               stim_start;
  logic               stim_stop;
  logic               stim_running;
  logic [1:0]         stop_cause;

  modport source (output valid, tilt_angle, stim_start, stim_stop, stim_running, stop_cause,
                  input ready);
  modport sink   (input valid, tilt_angle, stim_start, stim_stop, stim_running, stop_cause,
                  output ready);
endinterface

>>> hdl/tilt_gait_stim_trigger.sv
// Tilt gait stimulation trigger: CORDIC tilt angle plus arm/start/stop logic.
// Depends on tgst_pkg and the channel interfaces in tgst_if.sv.
//
//   channel   | dir | handshake           | payload
//   ----------+-----+---------------------+---------------------------------------------
//   in_chan   | in  | valid/ready         | op, accel_x, accel_y, accel_z
//   out_chan  | out | valid/ready         | tilt_angle, stim_start, stim_stop, ...
//   cfg (APB) | in  | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// A sample request steps from accept through PASS1, MUL_LO, MUL_HI, PASS2, ROUND and
// FINISH: one shared shift/add CORDIC unit iterates both vectoring passes and
// one 17x16 multiplier scales the magnitude in two halves. A tick skips to FINISH.
// in_chan.ready is high only while the sequencer is idle; a finished result may
// wait in the output register while the next request is taken. Reset is
// synchronous, active low, and needs no clearing pass.
module tilt_gait_stim_trigger #(
  parameter int CORDIC_STEPS    = tgst_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = tgst_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tgst_sample_if.sink                   in_chan,
  tgst_result_if.source                 out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgst_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tgst_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tgst_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import tgst_pkg::*;

  localparam int STEP_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int RND_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam int LIM_RAW   = 90 * (2 ** ANGLE_FRAC_BITS);
  localparam int ANG_LIM   = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

  // Sequencer and datapath registers
  seq_state_t                state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic signed [DATA_W-1:0]  x_r, x_nxt;
  logic signed [DATA_W-1:0]  y_r, y_nxt;
  logic signed [ANG_W-1:0]   z_r, z_nxt;
  logic signed [15:0]        a_r, a_nxt;
  logic [32:0]               prod_lo_r, prod_lo_nxt;
  logic                      zero_r, zero_nxt;
  logic                      tick_r, tick_nxt;
  logic signed [15:0]        ang_r, ang_nxt;

  // Trigger state
  logic signed [15:0]        prev_ang_r, prev_ang_nxt;
  logic signed [15:0]        cur_ang_r, cur_ang_nxt;
  logic signed [15:0]        ref_ang_r, ref_ang_nxt;
  logic                      armed_r, armed_nxt;
  logic                      detect_en_r, detect_en_nxt;
  logic                      active_r, active_nxt;
  logic [15:0]               timeout_left_r, timeout_left_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [15:0]        out_angle_r, out_angle_nxt;
  logic                      out_start_r, out_start_nxt;
  logic                      out_stop_r, out_stop_nxt;
  logic                      out_run_r, out_run_nxt;
  stop_cause_t               out_cause_r, out_cause_nxt;

  // Configuration registers
  logic                      axis_sel_r;
  logic signed [15:0]        trough_lim_r;
  logic signed [15:0]        arm_lim_r;
  logic [15:0]               release_rise_r;
  logic [15:0]               timeout_ticks_r;

  // Shared CORDIC and multiplier unit signals
  logic signed [DATA_W-1:0]  cor_dx, cor_dy, cor_x, cor_y;
  logic signed [ANG_W-1:0]   cor_t, cor_z;
  logic [MUL_W-1:0]          mul_a;
  logic [32:0]               mul_p;
  logic signed [ANG_W-1:0]   z_rnd;
  logic                      last_step;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Register write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_sel_r      <= AXIS_SELECT_RST;
      trough_lim_r    <= TROUGH_LIMIT_RST;
      arm_lim_r       <= ARM_LIMIT_RST;
      release_rise_r  <= RELEASE_RISE_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_AXIS_SELECT:   axis_sel_r      <= pwdata[0];
        REG_TROUGH_LIMIT:  trough_lim_r    <= pwdata[15:0];
        REG_ARM_LIMIT:     arm_lim_r       <= pwdata[15:0];
        REG_RELEASE_RISE:  release_rise_r  <= pwdata[15:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    case (paddr[4:2])
      REG_AXIS_SELECT:   prdata = {31'd0, axis_sel_r};
      REG_TROUGH_LIMIT:  prdata = {{16{trough_lim_r[15]}}, trough_lim_r};
      REG_ARM_LIMIT:     prdata = {{16{arm_lim_r[15]}}, arm_lim_r};
      REG_RELEASE_RISE:  prdata = {16'd0, release_rise_r};
      REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_r};
      default:           prdata = '0;
    endcase
  end

  // One vectoring micro-rotation: drive y toward zero
  always_comb begin
    cor_dx = y_r >>> step_r;
    cor_dy = x_r >>> step_r;
    cor_t  = ANG_W'(atan_deg_q16(ATAN_IDX_W'(step_r)));
    if (!y_r[DATA_W-1]) begin
      cor_x = x_r + cor_dx;
      cor_y = y_r - cor_dy;
      cor_z = z_r + cor_t;
    end else begin
      cor_x = x_r - cor_dx;
      cor_y = y_r + cor_dy;
      cor_z = z_r - cor_t;
    end
  end

  assign last_step = (step_r == STEP_W'(CORDIC_STEPS - 1));

  // Gain correction multiplier, low half then high half of the magnitude
  assign mul_a = (state_r == ST_MUL_HI) ? x_r[2*MUL_W-1:MUL_W] : x_r[MUL_W-1:0];
  assign mul_p = 33'(mul_a) * 33'(INV_GAIN_Q16);

  // Round half up to the output resolution
  assign z_rnd = (z_r + ANG_W'(2 ** (RND_SHIFT - 1))) >>> RND_SHIFT;

  // Sequencer, trigger decisions and output staging
  always_comb begin
    logic signed [15:0] a_sel, b_sel, c_sel;
    logic signed [16:0] b_abs;
    logic signed [15:0] ang;
    logic signed [17:0] rel_lim;
    logic               started, stopped;
    stop_cause_t        cause;
    logic               out_free;

    state_nxt        = state_r;
    step_nxt         = step_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    z_nxt            = z_r;
    a_nxt            = a_r;
    prod_lo_nxt      = prod_lo_r;
    zero_nxt         = zero_r;
    tick_nxt         = tick_r;
    ang_nxt          = ang_r;
    prev_ang_nxt     = prev_ang_r;
    cur_ang_nxt      = cur_ang_r;
    ref_ang_nxt      = ref_ang_r;
    armed_nxt        = armed_r;
    detect_en_nxt    = detect_en_r;
    active_nxt       = active_r;
    timeout_left_nxt = timeout_left_r;
    out_valid_nxt    = out_valid_r;
    out_angle_nxt    = out_angle_r;
    out_start_nxt    = out_start_r;
    out_stop_nxt     = out_stop_r;
    out_run_nxt      = out_run_r;
    out_cause_nxt    = out_cause_r;
    started          = 1'b0;
    stopped          = 1'b0;
    cause            = CAUSE_NONE;
    ang              = cur_ang_r;
    rel_lim          = '0;

    // Pick the axis roles
    if (axis_sel_r) begin
      a_sel = in_chan.accel_y;
      b_sel = in_chan.accel_x;
      c_sel = in_chan.accel_z;
    end else begin
      a_sel = in_chan.accel_z;
      b_sel = in_chan.accel_x;
      c_sel = in_chan.accel_y;
    end
    b_abs = b_sel[15] ? -17'(b_sel) : 17'(b_sel);

    // Drop the delivered result
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    out_free = !out_valid_r || out_chan.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          a_nxt    = a_sel;
          x_nxt    = DATA_W'(b_abs) <<< 16;
          y_nxt    = DATA_W'(c_sel) <<< 16;
          z_nxt    = '0;
          step_nxt = '0;
          tick_nxt = (in_chan.op == OP_TICK);
          state_nxt = (in_chan.op == OP_TICK) ? ST_FINISH : ST_PASS1;
        end
      end
      ST_PASS1: begin
        x_nxt    = cor_x;
        y_nxt    = cor_y;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        prod_lo_nxt = mul_p;
        state_nxt   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        // (hi*2^17 + lo) >> 16 == 2*hi + (lo >> 16)
        x_nxt     = (DATA_W'(mul_p) <<< 1) + DATA_W'(prod_lo_r[32:16]);
        y_nxt     = DATA_W'(a_r) <<< 16;
        z_nxt     = '0;
        step_nxt  = '0;
        zero_nxt  = (x_nxt == '0) && (a_r == '0);
        state_nxt = ST_PASS2;
      end
      ST_PASS2: begin
        x_nxt    = cor_x;
        y_nxt    = cor_y;
        z_nxt    = cor_z;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // Saturate to +-90 degrees; zero vector gives zero
        if (zero_r) begin
          ang_nxt = '0;
        end else if (z_rnd > ANG_W'(ANG_LIM)) begin
          ang_nxt = 16'(ANG_LIM);
        end else if (z_rnd < -ANG_W'(ANG_LIM)) begin
          ang_nxt = -16'(ANG_LIM);
        end else begin
          ang_nxt = z_rnd[15:0];
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          if (!tick_r) begin
            ang          = ang_r;
            prev_ang_nxt = cur_ang_r;
            cur_ang_nxt  = ang_r;
            // Arm on a rising angle inside the trough
            if (ang < trough_lim_r && ang > cur_ang_r && detect_en_r && !active_r &&
                ang < arm_lim_r) begin
              armed_nxt     = 1'b1;
              detect_en_nxt = 1'b0;
              ref_ang_nxt   = cur_ang_r;
            end
            // Start once the angle climbs above the reference
            if (armed_nxt && ang > ref_ang_nxt && !active_r) begin
              active_nxt       = 1'b1;
              armed_nxt        = 1'b0;
              timeout_left_nxt = timeout_ticks_r;
              started          = 1'b1;
            end
            // Stop on a large rise above the reference
            rel_lim = 18'(ref_ang_nxt) + $signed({2'b00, release_rise_r});
            if (active_nxt && 18'(ang) > rel_lim) begin
              active_nxt       = 1'b0;
              detect_en_nxt    = 1'b1;
              timeout_left_nxt = '0;
              stopped          = 1'b1;
              cause            = CAUSE_RISE;
            end
          end else if (active_r) begin
            // Count down the stimulation timeout
            if (timeout_left_r <= 16'd1) begin
              timeout_left_nxt = '0;
              active_nxt       = 1'b0;
              armed_nxt        = 1'b0;
              detect_en_nxt    = 1'b1;
              stopped          = 1'b1;
              cause            = CAUSE_TIMEOUT;
            end else begin
              timeout_left_nxt = timeout_left_r - 16'd1;
            end
          end
          out_valid_nxt = 1'b1;
          out_angle_nxt = cur_ang_nxt;
          out_start_nxt = started;
          out_stop_nxt  = stopped;
          out_run_nxt   = active_nxt;
          out_cause_nxt = cause;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      prev_ang_r     <= '0;
      cur_ang_r      <= '0;
      ref_ang_r      <= '0;
      armed_r        <= 1'b0;
      detect_en_r    <= 1'b1;
      active_r       <= 1'b0;
      timeout_left_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      prev_ang_r     <= prev_ang_nxt;
      cur_ang_r      <= cur_ang_nxt;
      ref_ang_r      <= ref_ang_nxt;
      armed_r        <= armed_nxt;
      detect_en_r    <= detect_en_nxt;
      active_r       <= active_nxt;
      timeout_left_r <= timeout_left_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    step_r      <= step_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    a_r         <= a_nxt;
    prod_lo_r   <= prod_lo_nxt;
    zero_r      <= zero_nxt;
    tick_r      <= tick_nxt;
    ang_r       <= ang_nxt;
    out_angle_r <= out_angle_nxt;
    out_start_r <= out_start_nxt;
    out_stop_r  <= out_stop_nxt;
    out_run_r   <= out_run_nxt;
    out_cause_r <= out_cause_nxt;
  end

  // Drive the channels
  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.tilt_angle   = out_angle_r;
  assign out_chan.stim_start   = out_start_r;
  assign out_chan.stim_stop    = out_stop_r;
  assign out_chan.stim_running = out_run_r;
  assign out_chan.stop_cause   = out_cause_r;

endmodule

>>> hdl/tgst_checker.sv
// Port-level checker for the tilt gait trigger, bound to the top level.
// Depends on tgst_pkg and the macros in tilt_gait_stim_trigger_assert.svh.
`include "tilt_gait_stim_trigger_assert.svh"

module tgst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_tilt_angle,
  input logic        out_stim_start,
  input logic        out_stim_stop,
  input logic        out_stim_running,
  input logic [1:0]  out_stop_cause
);
  import tgst_pkg::*;

  // No result may be offered in the cycle after reset
  `TGST_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // Hold a stalled result
  `TGST_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_tilt_angle), "stalled result changed")

  // One request at a time: busy right after an accept
  `TGST_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready held after accept")

  // A stop leaves stimulation off and names its cause
  `TGST_ASSERT(a_stop_cause, clk, rst_n, out_valid && out_stim_stop |-> !out_stim_running && (out_stop_cause == CAUSE_RISE || out_stop_cause == CAUSE_TIMEOUT), "bad stop result")

  // Without a stop the cause is none, and a start leaves stimulation running
  `TGST_ASSERT(a_no_stop, clk, rst_n, out_valid && !out_stim_stop |-> out_stop_cause == CAUSE_NONE && (!out_stim_start || out_stim_running), "bad non-stop result")

endmodule

bind tilt_gait_stim_trigger tgst_checker u_tgst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_tilt_angle   (out_chan.tilt_angle),
  .out_stim_start   (out_chan.stim_start),
  .out_stim_stop    (out_chan.stim_stop),
  .out_stim_running (out_chan.stim_running),
  .out_stop_cause   (out_chan.stop_cause)
);
